FILE: rtl/core/rbsi_pkg.sv
`timescale 1ns / 1ps

package rbsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int PROD_W    = DIFF_W + VAL_W;
    localparam int NUM_REGS  = 6;
    localparam int PIPE_LAT  = 6;

    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sd2147483648);

    // Configuration register indexes.
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [2:0][VAL_W-1:0] org;
        logic [2:0][VAL_W-1:0] dir;
        logic [VAL_W-1:0]      t_lo;
        logic [VAL_W-1:0]      t_hi;
    } side_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[VAL_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[VAL_W-1:0];
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/rbsi_if.sv
`timescale 1ns / 1ps

interface rbsi_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [rbsi_pkg::VAL_W-1:0] origin_x;
    logic signed [rbsi_pkg::VAL_W-1:0] origin_y;
    logic signed [rbsi_pkg::VAL_W-1:0] origin_z;
    logic signed [rbsi_pkg::VAL_W-1:0] dir_x;
    logic signed [rbsi_pkg::VAL_W-1:0] dir_y;
    logic signed [rbsi_pkg::VAL_W-1:0] dir_z;
    logic signed [rbsi_pkg::VAL_W-1:0] inv_dir_x;
    logic signed [rbsi_pkg::VAL_W-1:0] inv_dir_y;
    logic signed [rbsi_pkg::VAL_W-1:0] inv_dir_z;
    logic signed [rbsi_pkg::VAL_W-1:0] t_low;
    logic signed [rbsi_pkg::VAL_W-1:0] t_high;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    inv_dir_x, inv_dir_y, inv_dir_z, t_low, t_high, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  inv_dir_x, inv_dir_y, inv_dir_z, t_low, t_high, output ready);
endinterface

interface rbsi_out_if;
    logic                           valid;
    logic                           ready;
    logic                           is_hit;
    logic signed [rbsi_pkg::VAL_W-1:0] hit_distance;
    logic signed [rbsi_pkg::VAL_W-1:0] point_x;
    logic signed [rbsi_pkg::VAL_W-1:0] point_y;
    logic signed [rbsi_pkg::VAL_W-1:0] point_z;
    logic [2:0]                     normal_code;
    logic                           front_face;

    modport source (output valid, is_hit, hit_distance, point_x, point_y, point_z,
                    normal_code, front_face, input ready);
    modport sink (input valid, is_hit, hit_distance, point_x, point_y, point_z,
                  normal_code, front_face, output ready);
endinterface

FILE: rtl/core/rbsi_slab.sv
`timescale 1ns / 1ps

// One axis of the slab test: plane differences, products with the reciprocal,
// then floor shift and saturation. Three register stages, advanced by en.
module rbsi_slab (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [rbsi_pkg::VAL_W-1:0] plane_lo,
    input  logic signed [rbsi_pkg::VAL_W-1:0] plane_hi,
    input  logic signed [rbsi_pkg::VAL_W-1:0] org,
    input  logic signed [rbsi_pkg::VAL_W-1:0] inv,
    output logic signed [rbsi_pkg::VAL_W-1:0] near_t,
    output logic signed [rbsi_pkg::VAL_W-1:0] far_t
);

    logic signed [rbsi_pkg::DIFF_W-1:0] diff_lo_reg, diff_hi_reg;
    logic signed [rbsi_pkg::VAL_W-1:0]  inv_reg;
    logic signed [rbsi_pkg::PROD_W-1:0] prod_lo_reg, prod_hi_reg;
    logic signed [rbsi_pkg::VAL_W-1:0]  near_reg, far_reg;
    logic signed [rbsi_pkg::DIFF_W-1:0] diff_lo_next, diff_hi_next;
    logic signed [rbsi_pkg::PROD_W-1:0] prod_lo_next, prod_hi_next;

    assign diff_lo_next = {plane_lo[rbsi_pkg::VAL_W-1], plane_lo} - {org[rbsi_pkg::VAL_W-1], org};
    assign diff_hi_next = {plane_hi[rbsi_pkg::VAL_W-1], plane_hi} - {org[rbsi_pkg::VAL_W-1], org};
    assign prod_lo_next = diff_lo_reg * inv_reg;
    assign prod_hi_next = diff_hi_reg * inv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_lo_reg <= diff_lo_next;
            diff_hi_reg <= diff_hi_next;
            inv_reg     <= inv;
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
            // Arithmetic shift rounds toward minus infinity.
            near_reg    <= rbsi_pkg::sat32(prod_lo_reg >>> rbsi_pkg::FRAC_BITS);
            far_reg     <= rbsi_pkg::sat32(prod_hi_reg >>> rbsi_pkg::FRAC_BITS);
        end
    end

    assign near_t = near_reg;
    assign far_t  = far_reg;

endmodule

FILE: rtl/core/ray_box_slab_intersect.sv
`timescale 1ns / 1ps

// Channel   Dir   Width  Content
// cfg_*     in    3+32   box corner register writes, index 0..5
// in_ch     in    352    ray origin, direction, reciprocal, distance interval
// out_ch    out   133    hit flag, distance, hit point, normal code, front flag
//
// One ray is taken every cycle while the output is not stalled. There are six
// register stages: three for the slab products, then merge, point products and
// the output register. A result is presented from the output register once it
// has passed every stage. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stall holds every stage in place.
// Reset clears the valid bits and loads the unit box.
module ray_box_slab_intersect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [rbsi_pkg::VAL_W-1:0]        cfg_data,
    rbsi_in_if.sink                           in_ch,
    rbsi_out_if.source                        out_ch
);

    logic [rbsi_pkg::NUM_REGS-1:0][rbsi_pkg::VAL_W-1:0] box_reg;
    logic [rbsi_pkg::PIPE_LAT-1:0] v_reg;
    logic en;

    rbsi_pkg::side_t side_next;
    rbsi_pkg::side_t side_reg [4];

    logic signed [rbsi_pkg::VAL_W-1:0] org [3];
    logic signed [rbsi_pkg::VAL_W-1:0] dir [3];
    logic signed [rbsi_pkg::VAL_W-1:0] inv [3];
    logic signed [rbsi_pkg::VAL_W-1:0] n_t [3];
    logic signed [rbsi_pkg::VAL_W-1:0] f_t [3];

    // merge stage
    logic signed [rbsi_pkg::VAL_W-1:0] near_next, near_reg;
    logic [1:0] axis_next, axis_reg;
    logic miss_next, miss_reg;

    // product stage
    logic hit_next, hit_reg;
    logic signed [rbsi_pkg::VAL_W-1:0] dist_reg;
    logic signed [2*rbsi_pkg::VAL_W-1:0] pp_reg [3];
    logic [2:0] code_next, code_reg;
    logic front_next, front_reg;
    logic signed [rbsi_pkg::VAL_W-1:0] org4_reg [3];

    // output stage
    logic out_hit_reg, out_front_reg;
    logic signed [rbsi_pkg::VAL_W-1:0] out_dist_reg;
    logic signed [rbsi_pkg::VAL_W-1:0] out_pt_reg [3];
    logic [2:0] out_code_reg;
    logic signed [rbsi_pkg::VAL_W-1:0] pt_next [3];

    assign en = !v_reg[rbsi_pkg::PIPE_LAT-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg[rbsi_pkg::REG_MIN_X] <= '0;
            box_reg[rbsi_pkg::REG_MIN_Y] <= '0;
            box_reg[rbsi_pkg::REG_MIN_Z] <= '0;
            box_reg[rbsi_pkg::REG_MAX_X] <= rbsi_pkg::VAL_W'(1) << rbsi_pkg::FRAC_BITS;
            box_reg[rbsi_pkg::REG_MAX_Y] <= rbsi_pkg::VAL_W'(1) << rbsi_pkg::FRAC_BITS;
            box_reg[rbsi_pkg::REG_MAX_Z] <= rbsi_pkg::VAL_W'(1) << rbsi_pkg::FRAC_BITS;
        end
        else if (cfg_we && cfg_index <= rbsi_pkg::REG_MAX_Z)
        begin
            box_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[rbsi_pkg::PIPE_LAT-2:0], in_ch.valid};
    end

    assign org[0] = in_ch.origin_x;
    assign org[1] = in_ch.origin_y;
    assign org[2] = in_ch.origin_z;
    assign dir[0] = in_ch.dir_x;
    assign dir[1] = in_ch.dir_y;
    assign dir[2] = in_ch.dir_z;
    assign inv[0] = in_ch.inv_dir_x;
    assign inv[1] = in_ch.inv_dir_y;
    assign inv[2] = in_ch.inv_dir_z;

    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_axis
            logic signed [rbsi_pkg::VAL_W-1:0] lo_plane, hi_plane;
            // The near plane is the minimum corner unless the direction is negative.
            assign lo_plane = dir[a][rbsi_pkg::VAL_W-1] ? box_reg[3 + a] : box_reg[a];
            assign hi_plane = dir[a][rbsi_pkg::VAL_W-1] ? box_reg[a] : box_reg[3 + a];
            rbsi_slab u_slab (
                .clk      (clk),
                .en       (en),
                .plane_lo (lo_plane),
                .plane_hi (hi_plane),
                .org      (org[a]),
                .inv      (inv[a]),
                .near_t   (n_t[a]),
                .far_t    (f_t[a])
            );
        end
    endgenerate

    always_comb
    begin
        side_next.org[0] = org[0];
        side_next.org[1] = org[1];
        side_next.org[2] = org[2];
        side_next.dir[0] = dir[0];
        side_next.dir[1] = dir[1];
        side_next.dir[2] = dir[2];
        side_next.t_lo   = in_ch.t_low;
        side_next.t_hi   = in_ch.t_high;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
        end
    end

    // Merge x, y, z in order; a later axis wins near only when strictly greater.
    always_comb
    begin
        logic signed [rbsi_pkg::VAL_W-1:0] nt, ft;
        nt        = n_t[0];
        ft        = f_t[0];
        axis_next = rbsi_pkg::AXIS_X;
        miss_next = 1'b0;
        if (nt > f_t[1] || n_t[1] > ft)
            miss_next = 1'b1;
        if (n_t[1] > nt)
        begin
            nt        = n_t[1];
            axis_next = rbsi_pkg::AXIS_Y;
        end
        if (f_t[1] < ft)
            ft = f_t[1];
        if (nt > f_t[2] || n_t[2] > ft)
            miss_next = 1'b1;
        if (n_t[2] > nt)
        begin
            nt        = n_t[2];
            axis_next = rbsi_pkg::AXIS_Z;
        end
        near_next = nt;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg <= near_next;
            axis_reg <= axis_next;
            miss_reg <= miss_next;
        end
    end

    always_comb
    begin
        logic signed [rbsi_pkg::VAL_W-1:0] d;
        hit_next = !miss_reg && near_reg >= $signed(side_reg[3].t_lo)
                   && near_reg <= $signed(side_reg[3].t_hi);
        case (axis_reg)
            rbsi_pkg::AXIS_Y: d = side_reg[3].dir[1];
            rbsi_pkg::AXIS_Z: d = side_reg[3].dir[2];
            default:          d = side_reg[3].dir[0];
        endcase
        front_next = d != '0;
        // Minus axis for a positive direction; plus otherwise, zero included.
        code_next  = {axis_reg, 1'b0} | {2'b00, d <= 0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg   <= hit_next;
            dist_reg  <= near_reg;
            code_reg  <= code_next;
            front_reg <= front_next;
            for (int i = 0; i < 3; i++)
            begin
                pp_reg[i]   <= near_reg * $signed(side_reg[3].dir[i]);
                org4_reg[i] <= side_reg[3].org[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt_next[i] = rbsi_pkg::sat32(
                $signed({{(rbsi_pkg::PROD_W-rbsi_pkg::VAL_W){org4_reg[i][rbsi_pkg::VAL_W-1]}},
                         org4_reg[i]})
                + ($signed({pp_reg[i][2*rbsi_pkg::VAL_W-1], pp_reg[i]}) >>> rbsi_pkg::FRAC_BITS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg   <= hit_reg;
            out_dist_reg  <= hit_reg ? dist_reg : '0;
            out_code_reg  <= hit_reg ? code_reg : '0;
            out_front_reg <= hit_reg ? front_reg : 1'b0;
            for (int i = 0; i < 3; i++)
                out_pt_reg[i] <= hit_reg ? pt_next[i] : '0;
        end
    end

    assign out_ch.valid        = v_reg[rbsi_pkg::PIPE_LAT-1];
    assign out_ch.is_hit       = out_hit_reg;
    assign out_ch.hit_distance = out_dist_reg;
    assign out_ch.point_x      = out_pt_reg[0];
    assign out_ch.point_y      = out_pt_reg[1];
    assign out_ch.point_z      = out_pt_reg[2];
    assign out_ch.normal_code  = out_code_reg;
    assign out_ch.front_face   = out_front_reg;

endmodule
